// ----- src/lqs_pkg.sv -----
package lqs_pkg;

    localparam int DEPTH_DEFAULT = 8;
    localparam int WORD_W        = 32;
    localparam int SLOT_W        = 3;

    typedef enum logic [1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_SEARCH  = 2'd2,
        OP_DISPLAY = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_OVERFLOW  = 2'd1,
        STATUS_EMPTY     = 2'd2,
        STATUS_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_DISP,
        ST_PUSH
    } lqs_state_t;

    // memory port strobes from the controller
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

endpackage

// ----- src/lqs_in_if.sv -----
interface lqs_in_if
    import lqs_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [1:0]               opcode;
    logic signed [WORD_W-1:0] data_word;

    modport source (output valid, output opcode, output data_word, input ready);
    modport sink   (input valid, input opcode, input data_word, output ready);
endinterface

// ----- src/lqs_out_if.sv -----
interface lqs_out_if
    import lqs_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [1:0]               status;
    logic signed [WORD_W-1:0] word_out;
    logic [SLOT_W-1:0]        slot_index;
    logic                     last;

    modport source (output valid, output status, output word_out, output slot_index,
                    output last, input ready);
    modport sink   (input valid, input status, input word_out, input slot_index,
                    input last, output ready);
endinterface

// ----- src/lqs_mem.sv -----
module lqs_mem
    import lqs_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  mem_ctl_t          ctl,
    input  logic [AW-1:0]     waddr,
    input  logic [WORD_W-1:0] wdata,
    input  logic [AW-1:0]     raddr,
    output logic [WORD_W-1:0] rdata
);

    logic [WORD_W-1:0] mem_reg [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read, holds until the next read strobe
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/lqs_ctrl.sv -----
module lqs_ctrl
    import lqs_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    lqs_in_if.sink            req,
    lqs_out_if.source         rsp,
    output mem_ctl_t          mem_ctl,
    output logic [AW-1:0]     mem_waddr,
    output logic [WORD_W-1:0] mem_wdata,
    output logic [AW-1:0]     mem_raddr,
    input  logic [WORD_W-1:0] mem_rdata
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = (CW > SLOT_W) ? CW : SLOT_W;

    lqs_state_t        state_reg, state_next;
    logic [CW-1:0]     head_reg, head_next;
    logic [CW-1:0]     written_reg, written_next;
    logic [CW-1:0]     ptr_reg, ptr_next;
    logic [WORD_W-1:0] key_reg, key_next;
    status_t           res_status_reg, res_status_next;
    logic [WORD_W-1:0] res_word_reg, res_word_next;
    logic [SLOT_W-1:0] res_slot_reg, res_slot_next;

    logic              out_valid_reg;
    status_t           out_status_reg;
    logic [WORD_W-1:0] out_word_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    logic              out_last_reg;

    logic              out_load;
    status_t           out_status_d;
    logic [WORD_W-1:0] out_word_d;
    logic [SLOT_W-1:0] out_slot_d;
    logic              out_last_d;

    logic              out_free;
    logic              empty;
    logic [CW-1:0]     ptr_inc;
    logic              scan_end;
    logic [SW-1:0]     ptr_ext;
    logic [SLOT_W-1:0] ptr_slot;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign empty     = (head_reg >= written_reg);
    assign ptr_inc   = ptr_reg + CW'(1);
    assign scan_end  = (ptr_inc >= written_reg);
    assign ptr_ext   = SW'(ptr_reg);
    assign ptr_slot  = ptr_ext[SLOT_W-1:0];
    assign req.ready = (state_reg == ST_IDLE);
    assign mem_waddr = written_reg[AW-1:0];
    assign mem_wdata = req.data_word;

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        written_next    = written_reg;
        ptr_next        = ptr_reg;
        key_next        = key_reg;
        res_status_next = res_status_reg;
        res_word_next   = res_word_reg;
        res_slot_next   = res_slot_reg;
        mem_ctl         = '0;
        mem_raddr       = ptr_reg[AW-1:0];
        out_load        = 1'b0;
        out_status_d    = STATUS_OK;
        out_word_d      = '0;
        out_slot_d      = '0;
        out_last_d      = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                res_word_next = '0;
                res_slot_next = '0;
                if (req.valid)
                begin
                    state_next = ST_PUSH;
                    unique case (opcode_t'(req.opcode))
                        OP_ENQUEUE:
                        begin
                            if (written_reg == CW'(DEPTH))
                            begin
                                res_status_next = STATUS_OVERFLOW;
                            end
                            else
                            begin
                                mem_ctl.wr_en   = 1'b1;
                                written_next    = written_reg + CW'(1);
                                res_status_next = STATUS_OK;
                            end
                        end
                        OP_DEQUEUE:
                        begin
                            if (empty)
                            begin
                                res_status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                mem_ctl.rd_en = 1'b1;
                                mem_raddr     = head_reg[AW-1:0];
                                head_next     = head_reg + CW'(1);
                                state_next    = ST_READ;
                            end
                        end
                        OP_SEARCH,
                        OP_DISPLAY:
                        begin
                            if (empty)
                            begin
                                res_status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                mem_ctl.rd_en = 1'b1;
                                mem_raddr     = head_reg[AW-1:0];
                                ptr_next      = head_reg;
                                key_next      = req.data_word;
                                state_next    = (opcode_t'(req.opcode) == OP_SEARCH)
                                                ? ST_SCAN : ST_DISP;
                            end
                        end
                        default:
                        begin
                            res_status_next = STATUS_EMPTY;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                res_status_next = STATUS_OK;
                res_word_next   = mem_rdata;
                res_slot_next   = '0;
                state_next      = ST_PUSH;
            end
            ST_SCAN:
            begin
                res_word_next = '0;
                if (mem_rdata == key_reg)
                begin
                    res_status_next = STATUS_OK;
                    res_slot_next   = ptr_slot;
                    state_next      = ST_PUSH;
                end
                else if (scan_end)
                begin
                    res_status_next = STATUS_NOT_FOUND;
                    res_slot_next   = '0;
                    state_next      = ST_PUSH;
                end
                else
                begin
                    ptr_next      = ptr_inc;
                    mem_ctl.rd_en = 1'b1;
                    mem_raddr     = ptr_inc[AW-1:0];
                end
            end
            ST_DISP:
            begin
                if (out_free)
                begin
                    out_load     = 1'b1;
                    out_status_d = STATUS_OK;
                    out_word_d   = mem_rdata;
                    out_slot_d   = ptr_slot;
                    out_last_d   = scan_end;
                    if (scan_end)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ptr_next      = ptr_inc;
                        mem_ctl.rd_en = 1'b1;
                        mem_raddr     = ptr_inc[AW-1:0];
                    end
                end
            end
            ST_PUSH:
            begin
                if (out_free)
                begin
                    out_load     = 1'b1;
                    out_status_d = res_status_reg;
                    out_word_d   = res_word_reg;
                    out_slot_d   = res_slot_reg;
                    out_last_d   = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            written_reg   <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            written_reg <= written_next;
            ptr_reg     <= ptr_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        res_status_reg <= res_status_next;
        res_word_reg   <= res_word_next;
        res_slot_reg   <= res_slot_next;
        if (out_load)
        begin
            out_status_reg <= out_status_d;
            out_word_reg   <= out_word_d;
            out_slot_reg   <= out_slot_d;
            out_last_reg   <= out_last_d;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.word_out   = out_word_reg;
    assign rsp.slot_index = out_slot_reg;
    assign rsp.last       = out_last_reg;

endmodule

// ----- src/linear_queue_with_search_unit.sv -----
// channel | dir | transaction                         | payload
// req     | in  | one command (enqueue/dequeue/search/display) | opcode, data_word
// rsp     | out | one result; display gives one per live entry  | status, word_out,
//         |     |                                               | slot_index, last
//
// enqueue passes PUSH, dequeue READ and PUSH, search scans at most DEPTH entries
// in SCAN before PUSH, display gives one result per live entry; the single-port
// slot memory read, one entry per cycle unless rsp stalls, sets the scan length
// one command at a time: req.ready is high only while the controller is idle,
// and a new command is taken while the last result still waits in rsp
// reset clears head, written count, scan pointer and the output valid flag;
// slot contents are not cleared (only written slots are ever read)
// a stall on rsp freezes a display scan at the current entry
module linear_queue_with_search_unit
    import lqs_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    lqs_in_if.sink    req,
    lqs_out_if.source rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    mem_ctl_t          mem_ctl;
    logic [AW-1:0]     mem_waddr;
    logic [AW-1:0]     mem_raddr;
    logic [WORD_W-1:0] mem_wdata;
    logic [WORD_W-1:0] mem_rdata;

    // sequencer: counters, scan pointer, output register
    // an enqueue writes only at the written count and reads only go below it,
    // so a write and a later read never touch the same entry in one cycle
    lqs_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .mem_ctl   (mem_ctl),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // slot storage, one write and one registered read per cycle
    lqs_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .ctl   (mem_ctl),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // an accepted command always moves the sequencer out of idle, so req.ready drops
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("command accepted right after another");

    // no command may be taken in the middle of a display
    a_no_accept_mid_display: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.ready && !rsp.last |-> !req.ready)
        else $error("command taken during display");

    // only display entries can be non-final, and those are always ok
    a_nonlast_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.last |-> rsp.status == STATUS_OK)
        else $error("non-final result with error status");

    // error results are single and carry no word or slot
    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != STATUS_OK
        |-> rsp.last && rsp.word_out == '0 && rsp.slot_index == '0)
        else $error("error result with payload");

endmodule

// ----- tb/linear_queue_with_search_unit_test.sv -----
module linear_queue_with_search_unit_test;
    import lqs_pkg::*;

    // the block runs at its default depth, the same depth the predictor keeps
    localparam int QUEUE_DEPTH   = DEPTH_DEFAULT;
    localparam int DIRECTED_ROWS = 26;
    localparam int RANDOM_ITEMS  = 480;
    localparam int MAX_WAIT      = 8;
    // worst case is roughly 500 displays of QUEUE_DEPTH results, each result
    // held off by a full stall; the limit is several times that
    localparam int CYCLE_LIMIT   = 1_000_000;

    localparam logic [WORD_W-1:0] WORD_MAX = 32'h7fff_ffff;
    localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;
    localparam logic [WORD_W-1:0] ALL_ONES = 32'hffff_ffff;

    // one result transaction as the sink sees it
    typedef struct {
        status_t             status;
        logic [WORD_W-1:0]   word;
        logic [SLOT_W-1:0]   slot;
        logic                last;
    } queue_result_t;

    // one row of the directed table; typed rows carry their single result,
    // the rest are checked against the queue predictor
    typedef struct {
        opcode_t             op;
        logic [WORD_W-1:0]   word;
        bit                  typed;
        queue_result_t       result;
    } directed_row_t;

    localparam queue_result_t NOT_TYPED = '{STATUS_OK, 32'd0, 3'd0, 1'b0};

    logic clk;
    logic rst_n;

    lqs_in_if  req_if ();
    lqs_out_if rsp_if ();

    linear_queue_with_search_unit #(
        .DEPTH (QUEUE_DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // predictor copy of the queue: live entries are head_count .. written_count-1
    logic [WORD_W-1:0] slot_mem [QUEUE_DEPTH];
    int                head_count;
    int                written_count;

    // results still owed by the block, oldest first
    queue_result_t     pending_results [$];

    int                error_count;
    int                cycle_count;
    bit                src_steady;
    bit                sink_steady;
    directed_row_t     directed_rows [DIRECTED_ROWS];

    initial begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    // watchdog: a hung handshake or a lost result ends the run here
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic queue_result_t make_result(status_t status, logic [WORD_W-1:0] word,
                                                  logic [SLOT_W-1:0] slot, logic last);
        queue_result_t r;
        r.status = status;
        r.word   = word;
        r.slot   = slot;
        r.last   = last;
        return r;
    endfunction

    // applies one command to the predictor and lists the results it causes
    function automatic void apply_queue_command(opcode_t op, logic [WORD_W-1:0] word,
                                                ref queue_result_t outs [$]);
        bit found;
        found = 1'b0;
        case (op)
            OP_ENQUEUE:
            begin
                // linear queue: slots freed by dequeue are never reused
                if (written_count >= QUEUE_DEPTH)
                begin
                    outs.push_back(make_result(STATUS_OVERFLOW, '0, '0, 1'b1));
                end
                else
                begin
                    slot_mem[written_count] = word;
                    written_count++;
                    outs.push_back(make_result(STATUS_OK, '0, '0, 1'b1));
                end
            end
            OP_DEQUEUE:
            begin
                if (head_count >= written_count)
                begin
                    outs.push_back(make_result(STATUS_EMPTY, '0, '0, 1'b1));
                end
                else
                begin
                    outs.push_back(make_result(STATUS_OK, slot_mem[head_count], '0, 1'b1));
                    head_count++;
                end
            end
            OP_SEARCH:
            begin
                if (head_count >= written_count)
                begin
                    outs.push_back(make_result(STATUS_EMPTY, '0, '0, 1'b1));
                end
                else
                begin
                    // first match from the head wins
                    for (int i = head_count; i < written_count && !found; i++)
                    begin
                        if (slot_mem[i] == word)
                        begin
                            outs.push_back(make_result(STATUS_OK, '0, SLOT_W'(i), 1'b1));
                            found = 1'b1;
                        end
                    end
                    if (!found)
                    begin
                        outs.push_back(make_result(STATUS_NOT_FOUND, '0, '0, 1'b1));
                    end
                end
            end
            default:
            begin
                if (head_count >= written_count)
                begin
                    outs.push_back(make_result(STATUS_EMPTY, '0, '0, 1'b1));
                end
                else
                begin
                    for (int i = head_count; i < written_count; i++)
                    begin
                        outs.push_back(make_result(STATUS_OK, slot_mem[i], SLOT_W'(i),
                                                   (i + 1 == written_count)));
                    end
                end
            end
        endcase
    endfunction

    // mix of small repeated values, extremes and full-range words
    function automatic logic [WORD_W-1:0] draw_word();
        case ($urandom_range(0, 7))
            0, 1:    return WORD_W'($urandom_range(0, 5));
            2:
            begin
                case ($urandom_range(0, 3))
                    0:       return WORD_MAX;
                    1:       return WORD_MIN;
                    2:       return ALL_ONES;
                    default: return '0;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // drives one command, waits for its acceptance, then books the results
    task automatic issue_command(opcode_t op, logic [WORD_W-1:0] word, bit typed,
                                 queue_result_t typed_result);
        int gap;
        queue_result_t outs [$];
        // switch between bursts with no gaps and gappy stretches now and then
        if ($urandom_range(0, 39) == 0)
        begin
            src_steady = !src_steady;
        end
        gap = src_steady ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        // valid stays high straight into the next command when there is no gap
        req_if.valid     <= 1'b1;
        req_if.opcode    <= op;
        req_if.data_word <= word;
        do
        begin
            @(posedge clk);
        end
        while (!req_if.ready);
        apply_queue_command(op, word, outs);
        if (typed)
        begin
            pending_results.push_back(typed_result);
        end
        else
        begin
            foreach (outs[k])
            begin
                pending_results.push_back(outs[k]);
            end
        end
    endtask

    // hold the sender off until every booked result has come back
    task automatic drain_pause();
        req_if.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending_results.size() != 0);
    endtask

    // result sink: random stalls, compares every transaction with the oldest
    // booked result
    initial begin : result_sink
        int stall;
        queue_result_t exp;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                sink_steady = !sink_steady;
            end
            stall = sink_steady ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_if.ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!rsp_if.valid);
            if (pending_results.size() == 0)
            begin
                $error("result with none expected: status %0d word %h slot %0d last %0b",
                       rsp_if.status, rsp_if.word_out, rsp_if.slot_index, rsp_if.last);
                error_count++;
            end
            else
            begin
                exp = pending_results.pop_front();
                if (rsp_if.status !== exp.status)
                begin
                    $error("status: expected %0d, actual %0d", exp.status, rsp_if.status);
                    error_count++;
                end
                if (rsp_if.word_out !== exp.word)
                begin
                    $error("word_out: expected %h, actual %h", exp.word, rsp_if.word_out);
                    error_count++;
                end
                if (rsp_if.slot_index !== exp.slot)
                begin
                    $error("slot_index: expected %0d, actual %0d", exp.slot,
                           rsp_if.slot_index);
                    error_count++;
                end
                if (rsp_if.last !== exp.last)
                begin
                    $error("last: expected %0b, actual %0b", exp.last, rsp_if.last);
                    error_count++;
                end
            end
        end
    end

    initial begin : stimulus
        int r;
        opcode_t op;
        logic [WORD_W-1:0] word;

        error_count      = 0;
        cycle_count      = 0;
        head_count       = 0;
        written_count    = 0;
        src_steady       = 1'b0;
        sink_steady      = 1'b0;
        rst_n            = 1'b0;
        req_if.valid     = 1'b0;
        req_if.opcode    = OP_ENQUEUE;
        req_if.data_word = '0;
        rsp_if.ready     = 1'b0;

        // empty-queue answers, extremes, duplicate keys, dead entries after
        // dequeue, drained queue, and an enqueue into a fresh slot after draining
        directed_rows = '{
            '{OP_DEQUEUE, 32'hdead_beef, 1'b1, '{STATUS_EMPTY, 32'd0, 3'd0, 1'b1}},
            '{OP_SEARCH,  32'd0,         1'b1, '{STATUS_EMPTY, 32'd0, 3'd0, 1'b1}},
            '{OP_DISPLAY, 32'd0,         1'b1, '{STATUS_EMPTY, 32'd0, 3'd0, 1'b1}},
            '{OP_SEARCH,  ALL_ONES,      1'b1, '{STATUS_EMPTY, 32'd0, 3'd0, 1'b1}},
            '{OP_ENQUEUE, WORD_MAX,      1'b1, '{STATUS_OK, 32'd0, 3'd0, 1'b1}},
            '{OP_ENQUEUE, WORD_MIN,      1'b1, '{STATUS_OK, 32'd0, 3'd0, 1'b1}},
            '{OP_ENQUEUE, 32'd0,         1'b1, '{STATUS_OK, 32'd0, 3'd0, 1'b1}},
            '{OP_ENQUEUE, ALL_ONES,      1'b1, '{STATUS_OK, 32'd0, 3'd0, 1'b1}},
            '{OP_ENQUEUE, WORD_MIN,      1'b1, '{STATUS_OK, 32'd0, 3'd0, 1'b1}},
            '{OP_SEARCH,  WORD_MIN,      1'b1, '{STATUS_OK, 32'd0, 3'd1, 1'b1}},
            '{OP_SEARCH,  32'h1234_5678, 1'b1, '{STATUS_NOT_FOUND, 32'd0, 3'd0, 1'b1}},
            '{OP_DISPLAY, 32'd0,         1'b0, NOT_TYPED},
            '{OP_DEQUEUE, 32'd0,         1'b1, '{STATUS_OK, WORD_MAX, 3'd0, 1'b1}},
            '{OP_SEARCH,  WORD_MAX,      1'b1, '{STATUS_NOT_FOUND, 32'd0, 3'd0, 1'b1}},
            '{OP_DEQUEUE, ALL_ONES,      1'b1, '{STATUS_OK, WORD_MIN, 3'd0, 1'b1}},
            '{OP_SEARCH,  WORD_MIN,      1'b0, NOT_TYPED},
            '{OP_SEARCH,  32'd0,         1'b0, NOT_TYPED},
            '{OP_DEQUEUE, 32'd0,         1'b0, NOT_TYPED},
            '{OP_DEQUEUE, 32'd0,         1'b0, NOT_TYPED},
            '{OP_DISPLAY, 32'd0,         1'b0, NOT_TYPED},
            '{OP_DEQUEUE, 32'd0,         1'b0, NOT_TYPED},
            '{OP_DEQUEUE, 32'ha5a5_a5a5, 1'b1, '{STATUS_EMPTY, 32'd0, 3'd0, 1'b1}},
            '{OP_DISPLAY, 32'd0,         1'b1, '{STATUS_EMPTY, 32'd0, 3'd0, 1'b1}},
            '{OP_SEARCH,  WORD_MIN,      1'b1, '{STATUS_EMPTY, 32'd0, 3'd0, 1'b1}},
            '{OP_ENQUEUE, 32'h5a5a_5a5a, 1'b0, NOT_TYPED},
            '{OP_DISPLAY, 32'd0,         1'b0, NOT_TYPED}
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[n])
        begin
            issue_command(directed_rows[n].op, directed_rows[n].word,
                          directed_rows[n].typed, directed_rows[n].result);
        end
        drain_pause();

        // random part: enqueue-heavy until every slot has been used, then
        // mostly search and display over the live entries with slow draining
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            r = $urandom_range(0, 99);
            if (written_count < QUEUE_DEPTH)
            begin
                op = (r < 45) ? OP_ENQUEUE : (r < 60) ? OP_DEQUEUE :
                     (r < 85) ? OP_SEARCH : OP_DISPLAY;
            end
            else
            begin
                op = (r < 5) ? OP_ENQUEUE : (r < 13) ? OP_DEQUEUE :
                     (r < 65) ? OP_SEARCH : OP_DISPLAY;
            end
            // search keys mostly hit a live entry, some hit a dequeued one
            r = $urandom_range(0, 99);
            if (op == OP_SEARCH && head_count < written_count && r < 60)
            begin
                word = slot_mem[$urandom_range(head_count, written_count - 1)];
            end
            else if (op == OP_SEARCH && written_count > 0 && r < 75)
            begin
                word = slot_mem[$urandom_range(0, written_count - 1)];
            end
            else
            begin
                word = draw_word();
            end
            issue_command(op, word, 1'b0, NOT_TYPED);
            if ($urandom_range(0, 29) == 0)
            begin
                drain_pause();
            end
        end

        req_if.valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        // run on past the last result to catch stray ones
        repeat (QUEUE_DEPTH + 8) @(posedge clk);
        if (error_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
